[rtl/core/rldd_pkg.sv]
// Shared types, constants and helper functions of the run-length decoder with descrambling.
package rldd_pkg;

  localparam logic [3:0] HDR_LEN   = 4'd14;
  localparam logic [3:0] MAGIC_LEN = 4'd6;
  localparam logic [3:0] LEN_POS   = 4'd10;

  localparam logic [7:0] KEY_SINGLE_RST = 8'hA5;
  localparam logic [7:0] KEY_RUN_RST    = 8'h00;

  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic REG_KEY_SINGLE = 1'b0;
  localparam logic REG_KEY_RUN    = 1'b1;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_REP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_LEN       = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] repeat_res;
    logic       final_res;
    status_t    status;
  } rec_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0:    m = 8'h78;
      3'd1:    m = 8'h74;
      3'd2:    m = 8'h52;
      3'd3:    m = 8'h4C;
      3'd4:    m = 8'h45;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [Q_PTR_W-1:0] q_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + Q_PTR_W'(1);
    end
    return r;
  endfunction

endpackage

[rtl/core/rldd_if.sv]
// Valid/ready stream interfaces for packed-file bytes and decoded run records.
interface rldd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       file_end;
  modport source(output valid, file_byte, file_end, input ready);
  modport sink(input valid, file_byte, file_end, output ready);
endinterface

interface rldd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [6:0] repeat_res;
  logic       final_res;
  logic [1:0] status;
  modport source(output valid, out_byte, repeat_res, final_res, status, input ready);
  modport sink(input valid, out_byte, repeat_res, final_res, status, output ready);
endinterface

[rtl/core/rle_decode_and_descramble.sv]
// Top level of the run-length decoder with XOR descrambling and header checking.
// The block takes one packed-file byte per beat and can accept a byte in every cycle while
// at most one record waits; each byte is decoded by one level of compare and XOR logic and
// its zero, one or two run records are written straight into a three-entry result queue.
// The single output port drains that queue at one record per cycle while the receiver is
// ready, so a byte that yields two records leaves as two output beats.
// There is no clearing pass after reset. Keys may be written only while the block is idle.
module rle_decode_and_descramble (
  input  logic              clk,
  input  logic              rst_n,
  rldd_in_if.sink           in_if,
  rldd_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic [3:0]          hp_r, hp_nxt;
  logic                mg_r, mg_nxt;
  logic [31:0]         exp_r, exp_nxt;
  rldd_pkg::mode_t     mode_r, mode_nxt;
  logic [6:0]          cl_r, cl_nxt;
  logic [31:0]         prod_r, prod_nxt;
  logic [7:0]          prior_r, prior_nxt;
  logic                pv_r, pv_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                hv_r, hv_nxt;
  logic                heq_r, heq_nxt;
  logic                disc_r, disc_nxt;
  logic [7:0]          key_single_r, key_run_r;

  logic                acc;
  logic [7:0]          b;
  logic                g_valid;
  logic [7:0]          g_val;
  logic [6:0]          g_cnt;
  logic                g_run;
  logic [32:0]         prod_sum;
  logic [1:0]          lane;

  rldd_pkg::rec_t      recs [2];
  logic [1:0]          n_rec;
  rldd_pkg::status_t   st;
  logic                held_eq;
  logic [7:0]          held_key;

  rldd_pkg::rec_t      q_r [rldd_pkg::Q_DEPTH];
  logic [rldd_pkg::Q_PTR_W-1:0] rd_r, wr_r, wr1;
  logic [rldd_pkg::Q_CNT_W-1:0] qc_r;
  logic                pop;
  logic [rldd_pkg::Q_CNT_W-1:0] push_n;

  assign b     = in_if.file_byte;
  assign acc   = in_if.valid && in_if.ready;
  assign lane  = 2'(hp_r - rldd_pkg::LEN_POS);
  assign g_run = g_cnt >= 7'd2;

  // Header tracking, code parsing and neighbor state.
  always_comb begin
    hp_nxt    = hp_r;
    mg_nxt    = mg_r;
    exp_nxt   = exp_r;
    mode_nxt  = mode_r;
    cl_nxt    = cl_r;
    prod_nxt  = prod_r;
    prior_nxt = prior_r;
    pv_nxt    = pv_r;
    held_nxt  = held_r;
    hv_nxt    = hv_r;
    heq_nxt   = heq_r;
    disc_nxt  = disc_r;
    g_valid   = 1'b0;
    g_val     = b;
    g_cnt     = 7'd0;
    prod_sum  = 33'(prod_r) + 33'(cl_r);
    if (hp_r < rldd_pkg::HDR_LEN) begin
      if (hp_r < rldd_pkg::MAGIC_LEN) begin
        if (b != rldd_pkg::magic_byte(hp_r[2:0])) begin
          mg_nxt = 1'b0;
        end
      end else if (hp_r >= rldd_pkg::LEN_POS) begin
        exp_nxt[{lane, 3'b000} +: 8] = b;
      end
      hp_nxt = hp_r + 4'd1;
      if (hp_nxt == rldd_pkg::HDR_LEN && !mg_nxt) begin
        disc_nxt = 1'b1;
      end
    end else if (!disc_r) begin
      unique case (mode_r)
        rldd_pkg::MODE_CTRL: begin
          if (b != 8'h00) begin
            cl_nxt = b[6:0];
            if (b[7]) begin
              mode_nxt = (b[6:0] != 7'd0) ? rldd_pkg::MODE_LIT : rldd_pkg::MODE_CTRL;
            end else begin
              mode_nxt = rldd_pkg::MODE_REP;
            end
          end
        end
        rldd_pkg::MODE_LIT: begin
          g_valid = 1'b1;
          g_cnt   = 7'd1;
          cl_nxt  = cl_r - 7'd1;
          if (cl_nxt == 7'd0) begin
            mode_nxt = rldd_pkg::MODE_CTRL;
          end
        end
        rldd_pkg::MODE_REP: begin
          g_valid  = 1'b1;
          g_cnt    = cl_r;
          cl_nxt   = 7'd0;
          mode_nxt = rldd_pkg::MODE_CTRL;
        end
        default: begin
          mode_nxt = rldd_pkg::MODE_CTRL;
        end
      endcase
    end
    if (g_valid) begin
      prod_sum = 33'(prod_r) + 33'(g_cnt);
      prod_nxt = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
      if (g_run) begin
        prior_nxt = g_val;
        pv_nxt    = 1'b1;
        heq_nxt   = 1'b0;
        hv_nxt    = 1'b0;
      end else begin
        if (hv_r) begin
          prior_nxt = held_r;
          pv_nxt    = 1'b1;
          heq_nxt   = (g_val == held_r);
        end else begin
          heq_nxt   = pv_r && (prior_r == g_val);
        end
        held_nxt = g_val;
        hv_nxt   = 1'b1;
      end
    end
  end

  // Result records of the current beat.
  always_comb begin
    recs[0]  = '0;
    recs[1]  = '0;
    n_rec    = 2'd0;
    held_eq  = heq_r || (held_r == g_val);
    held_key = held_eq ? key_run_r : key_single_r;
    st       = rldd_pkg::ST_OK;
    if (g_valid) begin
      if (hv_r) begin
        recs[n_rec[0]].out_byte   = held_r ^ held_key;
        recs[n_rec[0]].repeat_res = 7'd1;
        n_rec = n_rec + 2'd1;
      end
      if (g_run) begin
        recs[n_rec[0]].out_byte   = g_val ^ key_run_r;
        recs[n_rec[0]].repeat_res = g_cnt;
        n_rec = n_rec + 2'd1;
      end
    end
    if (in_if.file_end) begin
      if (hv_nxt) begin
        recs[n_rec[0]].out_byte   = held_nxt ^ (heq_nxt ? key_run_r : key_single_r);
        recs[n_rec[0]].repeat_res = 7'd1;
        n_rec = n_rec + 2'd1;
      end
      if (!mg_nxt) begin
        st = rldd_pkg::ST_BAD_MAGIC;
      end else if (hp_nxt < rldd_pkg::HDR_LEN || mode_nxt != rldd_pkg::MODE_CTRL) begin
        st = rldd_pkg::ST_TRUNC;
      end else if (prod_nxt != exp_nxt) begin
        st = rldd_pkg::ST_LEN;
      end
      if (n_rec == 2'd0) begin
        n_rec = 2'd1;
      end
      recs[n_rec[0] ^ 1'b1].final_res = 1'b1;
      recs[n_rec[0] ^ 1'b1].status    = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_single_r <= rldd_pkg::KEY_SINGLE_RST;
      key_run_r    <= rldd_pkg::KEY_RUN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rldd_pkg::REG_KEY_SINGLE: key_single_r <= cfg_wdata;
        rldd_pkg::REG_KEY_RUN:    key_run_r    <= cfg_wdata;
        default:                  key_run_r    <= key_run_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_if.file_end)) begin
      hp_r    <= 4'd0;
      mg_r    <= 1'b1;
      exp_r   <= 32'd0;
      mode_r  <= rldd_pkg::MODE_CTRL;
      cl_r    <= 7'd0;
      prod_r  <= 32'd0;
      prior_r <= 8'd0;
      pv_r    <= 1'b0;
      held_r  <= 8'd0;
      hv_r    <= 1'b0;
      heq_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else if (acc) begin
      hp_r    <= hp_nxt;
      mg_r    <= mg_nxt;
      exp_r   <= exp_nxt;
      mode_r  <= mode_nxt;
      cl_r    <= cl_nxt;
      prod_r  <= prod_nxt;
      prior_r <= prior_nxt;
      pv_r    <= pv_nxt;
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
      heq_r   <= heq_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // Result queue: two free entries are needed to take a beat.
  assign in_if.ready = qc_r <= rldd_pkg::Q_CNT_W'(1);
  assign pop         = out_if.valid && out_if.ready;
  assign push_n      = acc ? rldd_pkg::Q_CNT_W'(n_rec) : '0;
  assign wr1         = rldd_pkg::q_inc(wr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      qc_r <= '0;
    end else begin
      if (pop) begin
        rd_r <= rldd_pkg::q_inc(rd_r);
      end
      if (push_n == rldd_pkg::Q_CNT_W'(1)) begin
        wr_r <= wr1;
      end else if (push_n == rldd_pkg::Q_CNT_W'(2)) begin
        wr_r <= rldd_pkg::q_inc(wr1);
      end
      qc_r <= qc_r + push_n - rldd_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rldd_pkg::Q_DEPTH; i++) begin
      if (push_n != '0 && wr_r == rldd_pkg::Q_PTR_W'(i)) begin
        q_r[i] <= recs[0];
      end
      if (push_n == rldd_pkg::Q_CNT_W'(2) && wr1 == rldd_pkg::Q_PTR_W'(i)) begin
        q_r[i] <= recs[1];
      end
    end
  end

  assign out_if.valid      = qc_r != '0;
  assign out_if.out_byte   = q_r[rd_r].out_byte;
  assign out_if.repeat_res = q_r[rd_r].repeat_res;
  assign out_if.final_res  = q_r[rd_r].final_res;
  assign out_if.status     = q_r[rd_r].status;

endmodule

[rtl/core/rldd_checker.sv]
// Port-level assertions of the run-length decoder and their binding to the top level.
module rldd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [6:0] repeat_res,
  input logic       final_res,
  input logic [1:0] status
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_byte, repeat_res, final_res, status}))
    else $error("result beat changed while stalled");

  // Status-only records close a file.
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && repeat_res == 7'd0 |-> final_res && out_byte == 8'h00)
    else $error("empty record that is not a final status record");

  // An error status appears only on the last record of a file.
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != rldd_pkg::ST_OK |-> final_res)
    else $error("error status on a record that is not final");

  // A bad magic discards the whole body, so it comes only on a status-only record.
  a_magic_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == rldd_pkg::ST_BAD_MAGIC |-> repeat_res == 7'd0)
    else $error("decoded data delivered with a bad magic");

endmodule

bind rle_decode_and_descramble rldd_checker u_rldd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .repeat_res (out_if.repeat_res),
  .final_res  (out_if.final_res),
  .status     (out_if.status)
);

[dv/rle_decode_and_descramble_chk.sv]
// Checker that predicts the run records of the decoder and compares them with the output beats.
module rle_decode_and_descramble_chk
  import rldd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rldd_in_if         in_ch,
  rldd_out_if        out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  localparam logic [7:0] SINGLE_KEY_INIT = 8'hA5;
  localparam logic [7:0] RUN_KEY_INIT    = 8'h00;
  localparam logic [3:0] HEADER_BYTES    = 4'd14;
  localparam logic [3:0] MAGIC_BYTES     = 4'd6;
  localparam logic [3:0] LENGTH_AT       = 4'd10;
  localparam logic [7:0] MAGIC_SEQ [6]   = '{8'h78, 8'h74, 8'h52, 8'h4C, 8'h45, 8'h00};
  localparam int         MAX_REPORTS     = 100;

  logic [7:0]  key_single_q;
  logic [7:0]  key_run_q;
  logic [3:0]  hdr_pos;
  logic        magic_ok;
  logic [31:0] hdr_len;
  mode_t       mode;
  logic [6:0]  count_left;
  logic [31:0] byte_total;
  logic [7:0]  last_sent;
  logic        last_sent_vld;
  logic [7:0]  held;
  logic        held_vld;
  logic        held_eq_last;
  logic        skipping;
  rec_t        expected_recs[$];
  int          step_recs;
  int          errors = 0;

  assign fail_count = errors;

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  function automatic void clear_file();
    hdr_pos       = '0;
    magic_ok      = 1'b1;
    hdr_len       = '0;
    mode          = MODE_CTRL;
    count_left    = '0;
    byte_total    = '0;
    last_sent     = '0;
    last_sent_vld = 1'b0;
    held          = '0;
    held_vld      = 1'b0;
    held_eq_last  = 1'b0;
    skipping      = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] value, input logic [6:0] copies);
    rec_t r;
    r.out_byte   = value;
    r.repeat_res = copies;
    r.final_res  = 1'b0;
    r.status     = ST_OK;
    expected_recs.push_back(r);
    step_recs++;
  endfunction

  function automatic void flush_held(input logic has_equal);
    emit(held ^ (has_equal ? key_run_q : key_single_q), 7'd1);
  endfunction

  function automatic void take_decoded(input logic [7:0] value, input logic [6:0] copies);
    logic [32:0] sum;
    sum = {1'b0, byte_total} + 33'(copies);
    byte_total = sum[32] ? '1 : sum[31:0];
    if (copies >= 7'd2) begin
      if (held_vld) begin
        flush_held(held_eq_last || held == value);
        held_vld = 1'b0;
      end
      emit(value ^ key_run_q, copies);
      last_sent     = value;
      last_sent_vld = 1'b1;
      held_eq_last  = 1'b0;
    end else begin
      if (held_vld) begin
        flush_held(held_eq_last || held == value);
        last_sent     = held;
        last_sent_vld = 1'b1;
        held_eq_last  = (value == held);
      end else begin
        held_eq_last = last_sent_vld && last_sent == value;
      end
      held     = value;
      held_vld = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    status_t st;
    rec_t    r;
    step_recs = 0;
    if (hdr_pos < HEADER_BYTES) begin
      if (hdr_pos < MAGIC_BYTES) begin
        if (b != MAGIC_SEQ[hdr_pos]) begin
          magic_ok = 1'b0;
        end
      end else if (hdr_pos >= LENGTH_AT) begin
        hdr_len[8 * int'(hdr_pos - LENGTH_AT) +: 8] = b;
      end
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos == HEADER_BYTES && !magic_ok) begin
        skipping = 1'b1;
      end
    end else if (!skipping) begin
      case (mode)
        MODE_CTRL: begin
          if (b != 8'h00) begin
            count_left = b[6:0];
            if (b[7]) begin
              mode = (count_left != '0) ? MODE_LIT : MODE_CTRL;
            end else begin
              mode = MODE_REP;
            end
          end
        end
        MODE_LIT: begin
          take_decoded(b, 7'd1);
          count_left = count_left - 7'd1;
          if (count_left == '0) begin
            mode = MODE_CTRL;
          end
        end
        default: begin
          take_decoded(b, count_left);
          count_left = '0;
          mode       = MODE_CTRL;
        end
      endcase
    end

    if (last) begin
      if (held_vld) begin
        flush_held(held_eq_last);
        held_vld = 1'b0;
      end
      if (!magic_ok) begin
        st = ST_BAD_MAGIC;
      end else if (hdr_pos < HEADER_BYTES || mode != MODE_CTRL) begin
        st = ST_TRUNC;
      end else if (byte_total != hdr_len) begin
        st = ST_LEN;
      end else begin
        st = ST_OK;
      end
      if (step_recs == 0) begin
        emit(8'h00, 7'd0);
      end
      r = expected_recs.pop_back();
      r.final_res = 1'b1;
      r.status    = st;
      expected_recs.push_back(r);
      clear_file();
    end
  endfunction

  task automatic check_record();
    rec_t want;
    if (expected_recs.size() == 0) begin
      report($sformatf("record with no expectation: byte %02h repeat %0d final %0b status %0d",
                       out_ch.out_byte, out_ch.repeat_res, out_ch.final_res, out_ch.status));
    end else begin
      want = expected_recs.pop_front();
      if (out_ch.out_byte !== want.out_byte) begin
        report($sformatf("out_byte %02h, expected %02h", out_ch.out_byte, want.out_byte));
      end
      if (out_ch.repeat_res !== want.repeat_res) begin
        report($sformatf("repeat_res %0d, expected %0d", out_ch.repeat_res, want.repeat_res));
      end
      if (out_ch.final_res !== want.final_res) begin
        report($sformatf("final_res %0b, expected %0b", out_ch.final_res, want.final_res));
      end
      if (out_ch.status !== want.status) begin
        report($sformatf("status %0d, expected %0d", out_ch.status, want.status));
      end
    end
  endtask

  // Input beats are predicted before output beats, so a record leaving in the same cycle is covered.
  always @(posedge clk) begin
    if (!rst_n) begin
      key_single_q = SINGLE_KEY_INIT;
      key_run_q    = RUN_KEY_INIT;
      clear_file();
      expected_recs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_SINGLE) begin
          key_single_q = cfg_wdata;
        end else begin
          key_run_q = cfg_wdata;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.file_byte, in_ch.file_end);
      end
      if (out_ch.valid && out_ch.ready) begin
        check_record();
      end
    end
    pending <= expected_recs.size();
  end

endmodule

[dv/rle_decode_and_descramble_tb.sv]
// Testbench top that feeds packed files to the decoder, varies the keys and gives the verdict.
module rle_decode_and_descramble_tb;
  import rldd_pkg::*;

  localparam int         RANDOM_BYTES  = 1200;
  localparam int         PHASES        = 5;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         TIMEOUT_UNITS = 8_000_000;
  localparam logic [7:0] CTRL_SKIP     = 8'h00;
  localparam logic [7:0] CTRL_LIT      = 8'h80;
  localparam logic [7:0] MAGIC_SEQ [6] = '{8'h78, 8'h74, 8'h52, 8'h4C, 8'h45, 8'h00};

  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SLOW, RX_CHOKE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        rx_ready = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int          fail_count;
  int          pending;
  int          sent_bytes = 0;
  int          burst_left = 0;
  logic [7:0]  last_val = 8'h00;
  logic [7:0]  body_q[$];

  rldd_in_if  in_ch();
  rldd_out_if out_ch();

  rle_decode_and_descramble i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rle_decode_and_descramble_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  assign out_ch.ready = rx_ready;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  rx_ready <= 1'b1;
      RX_BUSY:  rx_ready <= ($urandom_range(0, 9) < 7);
      RX_SLOW:  rx_ready <= (rx_left % 4 == 0);
      default:  rx_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.file_byte <= b;
    in_ch.file_end  <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
  endtask

  // Sends header plus body_q; bad_pos corrupts one magic byte and keep cuts the file short.
  task automatic send_file(input logic [31:0] len, input int bad_pos, input int keep);
    logic [7:0] img[$];
    int         i;
    for (i = 0; i < 6; i++) begin
      img.push_back(MAGIC_SEQ[i]);
    end
    if (bad_pos >= 0) begin
      img[bad_pos] = img[bad_pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    repeat (4) img.push_back(8'($urandom));
    for (i = 0; i < 4; i++) begin
      img.push_back(len[8*i +: 8]);
    end
    img = {img, body_q};
    body_q.delete();
    if (keep > 0) begin
      while (img.size() > keep) begin
        void'(img.pop_back());
      end
    end
    for (i = 0; i < img.size(); i++) begin
      send_byte(img[i], i == img.size() - 1);
    end
  endtask

  function automatic logic [7:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return last_val;
    end else if (roll < 6) begin
      case ($urandom_range(0, 2))
        0:       last_val = 8'h00;
        1:       last_val = 8'hFF;
        default: last_val = 8'h55;
      endcase
    end else begin
      last_val = 8'($urandom);
    end
    return last_val;
  endfunction

  function automatic int pick_count();
    if ($urandom_range(0, 11) == 0) begin
      return $urandom_range(0, 1) ? 127 : $urandom_range(5, 126);
    end
    return $urandom_range(1, 4);
  endfunction

  task automatic random_file();
    int          kind;
    int          cnt;
    int          bad_pos;
    int          keep;
    logic [31:0] total;
    logic [31:0] len;
    kind  = $urandom_range(0, 99);
    total = '0;
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        0: body_q.push_back(CTRL_SKIP);
        1: body_q.push_back(CTRL_LIT);
        2, 3, 4: begin
          cnt = pick_count();
          body_q.push_back(CTRL_LIT | 8'(cnt));
          repeat (cnt) body_q.push_back(pick_value());
          total += 32'(cnt);
        end
        default: begin
          cnt = pick_count();
          body_q.push_back(8'(cnt));
          body_q.push_back(pick_value());
          total += 32'(cnt);
        end
      endcase
    end
    len     = total;
    bad_pos = -1;
    keep    = -1;
    if (kind < 10) begin
      bad_pos = $urandom_range(0, 5);
    end else if (kind < 20) begin
      case ($urandom_range(0, 2))
        0:       len = total + 32'($urandom_range(1, 3));
        1:       len = total - 32'($urandom_range(1, 2));
        default: len = 32'($urandom);
      endcase
    end else if (kind < 30) begin
      keep = $urandom_range(1, 13 + body_q.size());
    end else if (kind < 34) begin
      bad_pos = $urandom_range(0, 5);
      keep    = $urandom_range(1, 13 + body_q.size());
    end
    send_file(len, bad_pos, keep);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_keys(input logic [7:0] single_key, input logic [7:0] run_key);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_SINGLE;
    cfg_wdata <= single_key;
    @(posedge clk);
    cfg_index <= REG_KEY_RUN;
    cfg_wdata <= run_key;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_files();
    body_q = {8'h83, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h11,
              8'h7F, 8'hFF, 8'h82, 8'hFF, 8'h42};
    send_file(32'd133, -1, -1);
    body_q = {8'h81, 8'h5A};
    send_file(32'd1, -1, -1);
    send_file(32'd0, -1, -1);
    body_q = {8'h02, 8'h33, 8'h81, 8'h34};
    send_file(32'd3, 0, -1);
    send_file(32'd0, -1, 5);
    send_file(32'd0, 2, 3);
    send_file(32'd0, -1, 1);
    body_q = {8'h84, 8'h10, 8'h11};
    send_file(32'd4, -1, -1);
    body_q = {8'h81, 8'h20, 8'h05};
    send_file(32'd6, -1, -1);
    body_q = {8'h03, 8'h77};
    send_file(32'hFFFF_FFFF, -1, -1);
    body_q = {8'h85, 8'h01};
    send_file(32'd5, 3, -1);
    body_q = {8'h83, 8'h01};
    send_file(32'd99, -1, -1);
  endtask

  initial begin
    int ph;
    int target;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_KEY_SINGLE;
    cfg_wdata       = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.file_byte = 8'h00;
    in_ch.file_end  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed_files();
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       set_keys(8'h00, 8'h00);
        1:       set_keys(8'hFF, 8'hFF);
        2:       set_keys(8'h00, 8'hFF);
        3:       set_keys(8'hFF, 8'h00);
        default: set_keys(8'($urandom), 8'($urandom));
      endcase
      target = sent_bytes + RANDOM_BYTES / PHASES;
      while (sent_bytes < target) begin
        random_file();
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("rle_decode_and_descramble_tb OK");
    end else begin
      $display("rle_decode_and_descramble_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("rle_decode_and_descramble_tb NOT OK");
    $finish;
  end

endmodule
